### src/fqa_pkg.sv
// ----------------------------------------------------------------------------
// fqa_pkg: shared types and helpers of the Q24.8 fixed-point ALU
// Word and fraction sizes, opcodes, the request and pipeline records and the
// saturating pack used by the back end.
// ----------------------------------------------------------------------------
package fqa_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 8;
    localparam int NUM_W         = WORD_BITS + FRACTION_BITS;   // divider numerator
    localparam int PROD_W        = 2 * WORD_BITS;
    localparam int MAG_W         = 2 * WORD_BITS + 1;
    localparam int EXT_W         = WORD_BITS + FRACTION_BITS + 2;
    localparam int PIPE_LEN      = NUM_W + 2;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
        OP_NE, OP_EQ, OP_INC, OP_DEC, OP_MIN, OP_MAX, OP_FROM_INT, OP_TO_INT
    } op_t;

    typedef struct packed {
        op_t                          op;
        logic signed [WORD_BITS-1:0]  a;
        logic signed [WORD_BITS-1:0]  b;
        logic [WORD_BITS-1:0]         a_mag;
        logic [WORD_BITS-1:0]         b_mag;
        logic                         a_neg;
        logic                         b_neg;
    } req_t;

    typedef struct packed {
        logic                         valid;
        req_t                         item;
    } req_head_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0]  value;
        logic                         cmp;
        logic                         ovf;
        logic                         dz;
    } res_t;

    typedef struct packed {
        logic                         valid;
        op_t                          op;
        logic                         neg;
        res_t                         res;
        logic [PROD_W-1:0]            prod;
        logic [NUM_W-1:0]             num;
        logic [WORD_BITS:0]           rem;
        logic [NUM_W-1:0]             quo;
        logic [WORD_BITS-1:0]         dvs;
    } pipe_t;

    localparam logic signed [EXT_W-1:0] SAT_MAX =
        {{(EXT_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Saturate a signed value of extended width into the word.
    function automatic res_t sat_signed(input logic signed [EXT_W-1:0] x);
        res_t r;
        r = '0;
        if (x > SAT_MAX) begin
            r.value = WORD_MAX;
            r.ovf   = 1'b1;
        end else if (x < SAT_MIN) begin
            r.value = WORD_MIN;
            r.ovf   = 1'b1;
        end else begin
            r.value = x[WORD_BITS-1:0];
        end
        return r;
    endfunction

    // Pack sign and magnitude into the word, saturating.
    function automatic res_t pack_mag(input logic neg, input logic [MAG_W-1:0] mag);
        res_t             r;
        logic [MAG_W-1:0] limit;
        r     = '0;
        limit = neg ? (MAG_W'(1) << (WORD_BITS - 1)) : ((MAG_W'(1) << (WORD_BITS - 1)) - 1'b1);
        if (mag > limit) begin
            r.value = neg ? WORD_MIN : WORD_MAX;
            r.ovf   = 1'b1;
        end else begin
            r.value = neg ? -$signed(mag[WORD_BITS-1:0]) : $signed(mag[WORD_BITS-1:0]);
        end
        return r;
    endfunction

    // One restoring division step: one quotient bit.
    function automatic pipe_t div_step(input pipe_t e);
        pipe_t            o;
        logic [WORD_BITS:0] r2;
        logic             qb;
        o  = e;
        r2 = {e.rem[WORD_BITS-1:0], e.num[NUM_W-1]};
        qb = 1'b0;
        if (r2 >= {1'b0, e.dvs}) begin
            r2 = r2 - {1'b0, e.dvs};
            qb = 1'b1;
        end
        o.num = e.num << 1;
        o.rem = r2;
        o.quo = {e.quo[NUM_W-2:0], qb};
        return o;
    endfunction

endpackage

### src/fqa_front.sv
// ----------------------------------------------------------------------------
// fqa_front: request intake
// Takes requests, splits operands into sign and magnitude and holds them in
// a two-entry queue ahead of the execution pipeline.
// ----------------------------------------------------------------------------
module fqa_front
    import fqa_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [3:0]                  opcode,
    input  logic signed [WORD_BITS-1:0] operand_a,
    input  logic signed [WORD_BITS-1:0] operand_b,
    output req_head_t                   head,
    input  logic                        take
);

    req_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    req_t       item;
    logic       do_push, do_pop;

    always_comb
    begin
        item.op    = op_t'(opcode);
        item.a     = operand_a;
        item.b     = operand_b;
        item.a_neg = operand_a[WORD_BITS-1];
        item.b_neg = operand_b[WORD_BITS-1];
        item.a_mag = item.a_neg ? WORD_BITS'(-operand_a) : WORD_BITS'(operand_a);
        item.b_mag = item.b_neg ? WORD_BITS'(-operand_b) : WORD_BITS'(operand_b);
    end

    assign full       = (count_reg == 2'd2);
    assign do_push    = push && !full;
    assign do_pop     = take && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

### src/fqa_back.sv
// ----------------------------------------------------------------------------
// fqa_back: execution pipeline
// Simple operations finish on entry, the product is rounded in the next
// stage, and division runs one quotient bit per stage; all ride one pipeline.
// ----------------------------------------------------------------------------
module fqa_back
    import fqa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_head_t head,
    output logic      take,
    input  logic      out_full,
    output logic      res_valid,
    output res_t      res
);

    pipe_t pipe_reg  [PIPE_LEN];
    pipe_t pipe_next [PIPE_LEN];
    logic  advance;
    pipe_t first;

    assign advance   = !pipe_reg[PIPE_LEN-1].valid || !out_full;
    assign take      = advance && head.valid;
    assign res_valid = advance && pipe_reg[PIPE_LEN-1].valid;
    assign res       = pipe_reg[PIPE_LEN-1].res;

    always_comb
    begin
        logic signed [EXT_W-1:0] ea, eb;
        req_t                    it;
        it = head.item;
        ea = EXT_W'(it.a);
        eb = EXT_W'(it.b);
        first       = '0;
        first.valid = head.valid;
        first.op    = it.op;
        first.neg   = it.a_neg ^ it.b_neg;
        first.prod  = PROD_W'(it.a_mag) * PROD_W'(it.b_mag);
        first.num   = {it.a_mag, {FRACTION_BITS{1'b0}}};
        first.dvs   = it.b_mag;
        unique case (it.op)
            OP_ADD:      first.res = sat_signed(ea + eb);
            OP_SUB:      first.res = sat_signed(ea - eb);
            OP_INC:      first.res = sat_signed(ea + EXT_W'(1));
            OP_DEC:      first.res = sat_signed(ea - EXT_W'(1));
            OP_FROM_INT: first.res = sat_signed(ea <<< FRACTION_BITS);
            OP_TO_INT:   first.res.value = it.a >>> FRACTION_BITS;
            OP_MIN:      first.res.value = (it.a < it.b) ? it.a : it.b;
            OP_MAX:      first.res.value = (it.a > it.b) ? it.a : it.b;
            OP_GT:       first.res.cmp = (it.a >  it.b);
            OP_LT:       first.res.cmp = (it.a <  it.b);
            OP_GE:       first.res.cmp = (it.a >= it.b);
            OP_LE:       first.res.cmp = (it.a <= it.b);
            OP_NE:       first.res.cmp = (it.a != it.b);
            OP_EQ:       first.res.cmp = (it.a == it.b);
            OP_DIV:
            begin
                if (it.b_mag == '0)
                begin
                    first.res.dz = 1'b1;
                    if (it.a_mag == '0)
                        first.res.value = '0;
                    else
                        first.res.value = it.a_neg ? WORD_MIN : WORD_MAX;
                end
            end
            default:     first.res = '0;
        endcase
    end

    always_comb
    begin
        logic [WORD_BITS-1:0] r;
        logic                 rnd;
        pipe_next[0] = first;
        for (int i = 1; i < PIPE_LEN; i++)
        begin
            if (i <= NUM_W)
                pipe_next[i] = div_step(pipe_reg[i-1]);
            else
                pipe_next[i] = pipe_reg[i-1];
        end
        if (pipe_reg[0].op == OP_MUL)
        begin
            pipe_next[1].res = pack_mag(pipe_reg[0].neg,
                MAG_W'((pipe_reg[0].prod + (PROD_W'(1) << (FRACTION_BITS - 1)))
                       >> FRACTION_BITS));
        end
        r   = pipe_reg[PIPE_LEN-2].rem[WORD_BITS-1:0];
        rnd = (r >= (pipe_reg[PIPE_LEN-2].dvs - r));
        if (pipe_reg[PIPE_LEN-2].op == OP_DIV && !pipe_reg[PIPE_LEN-2].res.dz)
        begin
            pipe_next[PIPE_LEN-1].res = pack_mag(pipe_reg[PIPE_LEN-2].neg,
                MAG_W'(pipe_reg[PIPE_LEN-2].quo) + MAG_W'(rnd));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LEN; i++)
                pipe_reg[i].valid <= 1'b0;
        end
        else if (advance)
        begin
            for (int i = 0; i < PIPE_LEN; i++)
                pipe_reg[i] <= pipe_next[i];
        end
    end

endmodule

### src/fqa_outq.sv
// ----------------------------------------------------------------------------
// fqa_outq: result queue
// Two-entry queue that parts the pipeline from the consumer.
// ----------------------------------------------------------------------------
module fqa_outq
    import fqa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  res_t wr_data,
    output logic q_full,
    input  logic pop,
    output logic empty,
    output res_t rd_data
);

    res_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign q_full  = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu: signed Q24.8 fixed-point ALU
// Exact integer arithmetic with rounding half away from zero and saturation.
//
//  Channel   Handshake        Payload
//  request   push / full      opcode, operand_a, operand_b
//  result    empty / pop      result_value, compare_true, overflow,
//                             divide_by_zero
//
// One request is accepted per cycle while full is low, and one result
// leaves per cycle while empty is low and pop is high. For every opcode
// an accepted request moves from the intake queue into the entry stage,
// through the forty quotient-bit stages of the divider and the rounding
// stage, and then lands in the result queue. All opcodes share that
// pipeline, so results stay in order.
// Reset clears the queues and the pipeline valid flags at once.
// A stalled consumer stops the pipeline; the two queues then fill and full
// rises, so no request or result is lost.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu
    import fqa_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [3:0]                  opcode,
    input  logic signed [WORD_BITS-1:0] operand_a,
    input  logic signed [WORD_BITS-1:0] operand_b,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [WORD_BITS-1:0] result_value,
    output logic                        compare_true,
    output logic                        overflow,
    output logic                        divide_by_zero
);

    req_head_t head;
    logic      take;
    logic      out_full;
    logic      res_valid;
    res_t      res;
    res_t      rd_data;

    // Front end: intake and operand split.
    fqa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .head      (head),
        .take      (take)
    );

    // Back end: execution pipeline, stalls as a whole on a full result queue while its last stage holds a result.
    fqa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .take      (take),
        .out_full  (out_full),
        .res_valid (res_valid),
        .res       (res)
    );

    fqa_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .q_full  (out_full),
        .pop     (pop),
        .empty   (empty),
        .rd_data (rd_data)
    );

    assign result_value   = rd_data.value;
    assign compare_true   = rd_data.cmp;
    assign overflow       = rd_data.ovf;
    assign divide_by_zero = rd_data.dz;

    // The pipeline never writes into a full result queue.
    assert property (@(posedge clk) disable iff (!rst_n) res_valid |-> !out_full)
        else $error("result written into full queue");

    // A divide-by-zero result never also reports saturation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && divide_by_zero) |-> !overflow)
        else $error("divide by zero with overflow");

    // A comparison result carries a zero value and no flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && compare_true) |-> (result_value == '0 && !overflow && !divide_by_zero))
        else $error("comparison result not clean");

endmodule
